/* design/hpa_pkg.sv */
// shared types and codes for the handle pool allocator
// no dependencies; imported by the controller, the datapath and the top level
package hpa_pkg;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_INSUFF   = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // register index of pool_size
  localparam logic REG_POOL_SIZE = 1'b0;

  typedef struct packed {
    logic load;
    logic free_rd;
    logic grant;
    logic insuff;
    logic srch_start;
    logic srch_next;
    logic sh_rd;
    logic sh_wr;
    logic rel;
    logic not_used;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op;
    logic count_zero;
    logic insufficient;
    logic used_empty;
    logic slot_free;
    logic grant_last;
    logic match;
    logic search_end;
    logic shift_end;
  } ctrl_stat_t;

endpackage

/* design/hpa_ram.sv */
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/hpa_ctrl.sv */
// controller state machine of the handle pool allocator
// depends on hpa_pkg; drives the datapath through ctrl_cmd_t, reads ctrl_stat_t
module hpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hpa_pkg::ctrl_stat_t stat,
  output hpa_pkg::ctrl_cmd_t  cmd,
  output logic               in_stall
);
  import hpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_GRANT,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_REL_OUT,
    S_MISS_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op == OP_REQUEST) begin
          priority if (stat.count_zero) begin
            state_next = S_IDLE;
          end else if (stat.insufficient) begin
            if (stat.slot_free) begin
              cmd.insuff = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            cmd.free_rd = 1'b1;
            state_next  = S_GRANT;
          end
        end else begin
          if (stat.used_empty) begin
            state_next = S_MISS_OUT;
          end else begin
            cmd.srch_start = 1'b1;
            state_next     = S_SRCH_CMP;
          end
        end
      end
      S_GRANT: begin
        if (stat.slot_free) begin
          cmd.grant = 1'b1;
          if (stat.grant_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.free_rd = 1'b1;
          end
        end
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          if (stat.search_end) begin
            state_next = S_REL_OUT;
          end else begin
            cmd.sh_rd  = 1'b1;
            state_next = S_SH_WR;
          end
        end else begin
          if (stat.search_end) begin
            state_next = S_MISS_OUT;
          end else begin
            cmd.srch_next = 1'b1;
          end
        end
      end
      S_SH_RD: begin
        cmd.sh_rd  = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = stat.shift_end ? S_REL_OUT : S_SH_RD;
      end
      S_REL_OUT: begin
        if (stat.slot_free) begin
          cmd.rel    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MISS_OUT: begin
        if (stat.slot_free) begin
          cmd.not_used = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* design/hpa_datapath.sv */
// datapath of the handle pool allocator: free fifo, used list, counters, result register
// depends on hpa_pkg and hpa_ram; commanded by hpa_ctrl
module hpa_datapath #(
  parameter int POOL_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hpa_pkg::ctrl_cmd_t                  cmd,
  output hpa_pkg::ctrl_stat_t                 stat,
  input  logic                                op_in,
  input  logic [5:0]                          count_in,
  input  logic [4:0]                          handle_in,
  input  logic                                cfg_we,
  input  logic [5:0]                          cfg_wdata,
  output logic [$clog2(POOL_DEPTH+1)-1:0]     pool_size,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [4:0]                          granted_handle,
  output logic [1:0]                          status,
  output logic                                last,
  output logic [5:0]                          free_count
);
  import hpa_pkg::*;

  localparam int AW       = $clog2(POOL_DEPTH);
  localparam int CW       = $clog2(POOL_DEPTH + 1);
  localparam int CMPW     = (AW > 5) ? AW : 5;
  localparam int KW       = (CW > 6) ? CW : 6;
  localparam int RESET_PS = (POOL_DEPTH < 32) ? POOL_DEPTH : 32;

  logic            op_q;
  logic [5:0]      count_q;
  logic [4:0]      handle_q;
  logic [5:0]      remain;
  logic [CW-1:0]   free_total;
  logic [CW-1:0]   used_total;
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [AW-1:0]   idx;
  logic [POOL_DEPTH-1:0] init_bits;
  logic            init_q;
  logic [AW-1:0]   head_q;

  logic [AW-1:0]   free_q;
  logic [AW-1:0]   used_q;
  logic [AW-1:0]   free_entry;
  logic [AW-1:0]   used_waddr;
  logic [AW-1:0]   used_wdata;
  logic [AW-1:0]   used_raddr;
  logic [CW-1:0]   ps_new;
  logic [AW-1:0]   tail_new;
  logic            emit;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(POOL_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // free list entries never written since the last refill read as their own slot number
  assign free_entry = init_q ? head_q : free_q;

  assign ps_new   = (KW'(cfg_wdata) > KW'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(cfg_wdata);
  assign tail_new = (ps_new == CW'(POOL_DEPTH)) ? '0 : AW'(ps_new);

  assign used_waddr = cmd.grant ? AW'(used_total) : idx;
  assign used_wdata = cmd.grant ? free_entry : used_q;
  assign used_raddr = cmd.srch_start ? '0 : idx + AW'(1);

  assign emit = cmd.grant | cmd.insuff | cmd.rel | cmd.not_used;

  hpa_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (cmd.rel),
    .waddr (tail),
    .wdata (AW'(handle_q)),
    .re    (cmd.free_rd),
    .raddr (head),
    .rdata (free_q)
  );

  hpa_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_used_ram (
    .clk   (clk),
    .we    (cmd.grant | cmd.sh_wr),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (cmd.srch_start | cmd.srch_next | cmd.sh_rd),
    .raddr (used_raddr),
    .rdata (used_q)
  );

  always_comb begin
    stat.op           = op_q;
    stat.count_zero   = (count_q == 6'd0);
    stat.insufficient = (KW'(count_q) > KW'(free_total));
    stat.used_empty   = (used_total == '0);
    stat.slot_free    = !out_valid || !out_stall;
    stat.grant_last   = (remain == 6'd1);
    stat.match        = (CMPW'(used_q) == CMPW'(handle_q));
    stat.search_end   = ((CW'(idx) + CW'(1)) == used_total);
    stat.shift_end    = ((CW'(idx) + CW'(2)) == used_total);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= CW'(RESET_PS);
      free_total <= CW'(RESET_PS);
      used_total <= '0;
      head       <= '0;
      tail       <= (RESET_PS == POOL_DEPTH) ? '0 : AW'(RESET_PS);
      init_bits  <= '1;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_size  <= ps_new;
        free_total <= ps_new;
        used_total <= '0;
        head       <= '0;
        tail       <= tail_new;
        init_bits  <= '1;
      end else begin
        if (cmd.free_rd) begin
          head <= ptr_inc(head);
        end
        if (cmd.grant) begin
          used_total <= used_total + CW'(1);
          free_total <= free_total - CW'(1);
        end
        if (cmd.rel) begin
          tail            <= ptr_inc(tail);
          init_bits[tail] <= 1'b0;
          used_total      <= used_total - CW'(1);
          free_total      <= free_total + CW'(1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op_in;
      count_q  <= count_in;
      handle_q <= handle_in;
      remain   <= count_in;
    end else if (cmd.grant) begin
      remain <= remain - 6'd1;
    end
    if (cmd.free_rd) begin
      init_q <= init_bits[head];
      head_q <= head;
    end
    if (cmd.srch_start) begin
      idx <= '0;
    end else if (cmd.srch_next || cmd.sh_wr) begin
      idx <= idx + AW'(1);
    end
    if (cmd.grant) begin
      granted_handle <= 5'(free_entry);
      status         <= ST_GRANTED;
      last           <= stat.grant_last;
      free_count     <= 6'(free_total - CW'(1));
    end else if (cmd.insuff) begin
      granted_handle <= 5'd0;
      status         <= ST_INSUFF;
      last           <= 1'b1;
      free_count     <= 6'(free_total);
    end else if (cmd.rel) begin
      granted_handle <= handle_q;
      status         <= ST_RELEASED;
      last           <= 1'b1;
      free_count     <= 6'(free_total + CW'(1));
    end else if (cmd.not_used) begin
      granted_handle <= handle_q;
      status         <= ST_NOT_USED;
      last           <= 1'b1;
      free_count     <= 6'(free_total);
    end
  end

`ifndef SYNTHESIS
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(free_total) + (CW+1)'(used_total)) == (CW+1)'(pool_size))
    else $error("free and used totals do not add up to pool size");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= CW'(POOL_DEPTH))
    else $error("free total above pool depth");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("result written while previous result is held");

  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.grant, cmd.insuff, cmd.rel, cmd.not_used}))
    else $error("more than one result source in one cycle");
`endif

endmodule

/* design/handle_pool_allocator.sv */
// handle pool allocator top level: apb register port, controller and datapath
// depends on hpa_pkg, hpa_ctrl, hpa_datapath (and hpa_ram through the datapath)
//
// usage
//   input channel (in_valid/in_stall): op, count, handle. a request asks for count
//   handles all or nothing; a release returns one handle.
//   output channel (out_valid/out_stall): granted_handle, status, last, free_count.
//   a granted request gives count results, the final one with last set; every
//   other request gives one result. a request with count zero gives none.
//   a request of n handles reads one handle per cycle from the free fifo ram while
//   the output register is free to take it. a release of the handle at position
//   k of u used entries does a used-list ram scan of one entry per cycle, then a
//   compaction of the u-1-k entries behind it, each read and then written back
//   one place lower. a miss scans all u entries.
//   a new request is taken whenever the previous one is done, even while its
//   last result still waits in the output register; while out_stall is high the
//   result holds and the block waits before writing the next one.
//   reset: pool_size becomes 32 (capped at POOL_DEPTH), free fifo holds handles
//   0 upward, used list empty. writing pool_size (address 0) does the same refill.
module handle_pool_allocator #(
  parameter int POOL_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [5:0]  count,
  input  logic [4:0]  handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  granted_handle,
  output logic [1:0]  status,
  output logic        last,
  output logic [5:0]  free_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hpa_pkg::*;

  localparam int CW = $clog2(POOL_DEPTH + 1);

  ctrl_cmd_t     cmd;
  ctrl_stat_t    stat;
  logic          cfg_we;
  logic [CW-1:0] pool_size;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);
  assign prdata = (paddr[2] == REG_POOL_SIZE) ? 32'(pool_size) : 32'd0;

  hpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  hpa_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op_in          (op),
    .count_in       (count),
    .handle_in      (handle),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[5:0]),
    .pool_size      (pool_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_handle (granted_handle),
    .status         (status),
    .last           (last),
    .free_count     (free_count)
  );

endmodule
